// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold whenever the antecedent holds, same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ldrt_pkg.sv
// ----------------------------------------------------------------------------
// ldrt_pkg
// shared constants for the longest distinct run tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ldrt_pkg;

  localparam int unsigned AlphabetSize = 256;
  localparam int unsigned SymW         = 8;
  localparam int unsigned PosW         = 16;
  localparam int unsigned LenW         = 9;
  localparam int unsigned MaxLen       = 65535;

  localparam logic [PosW-1:0] MaxLenPos = PosW'(MaxLen);

  typedef logic [SymW-1:0] sym_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [LenW-1:0] len_t;

endpackage

`default_nettype wire

// File: sv/ldrt_ram.sv
// ----------------------------------------------------------------------------
// ldrt_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ldrt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/longest_distinct_run_tracker_core.sv
// longest_distinct_run_tracker_core
// result: registered in the output stage when the last byte leaves stage 1
// throughput: one byte per cycle unless stalled by a pending result, set by the single
//   read-modify-write of the position table per byte, its write forwarded to the next byte
// reset: asynchronous, active low; the per-entry seen bits clear at once, no clearing pass
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker_core
// tracks the longest run of distinct bytes in a string streamed one byte per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module longest_distinct_run_tracker_core
  import ldrt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire logic        s_axis_tlast,   // last byte of the string
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [8:0] longest, [15:9] zero
  output logic             m_axis_tuser    // [0] overflow
);

`include "assert_macros.svh"

  // --------------------------------------------------------------------------
  // stage 0: accept a byte and issue the table read
  // --------------------------------------------------------------------------
  logic in_xfer;
  logic s1_fire;

  logic s1_vld_q, s1_vld_d;
  sym_t s1_ch_q;
  logic s1_last_q;

  // the byte of a string is reduced modulo the alphabet; with a full byte
  // alphabet this is the byte itself
  sym_t in_sym;
  assign in_sym = SymW'(s_axis_tdata % AlphabetSize);

  assign s_axis_tready = !s1_vld_q || s1_fire;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // position table: last position of each byte value within the string
  // --------------------------------------------------------------------------
  logic tbl_we;
  pos_t tbl_rdata;
  pos_t pos_q, pos_d;

  ldrt_ram #(
    .Width (PosW),
    .Depth (AlphabetSize)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s1_ch_q),
    .wdata_i (pos_q),
    .re_i    (in_xfer),
    .raddr_i (in_sym),
    .rdata_o (tbl_rdata)
  );

  // seen bits: a byte value counts as seen only while its bit is set,
  // all cleared at once at the end of each string
  logic [AlphabetSize-1:0] seen_q, seen_d;

  // last table write, forwarded to the byte that read in the same cycle
  logic fwd_vld_q, fwd_vld_d;
  sym_t fwd_addr_q;
  pos_t fwd_data_q;

  // --------------------------------------------------------------------------
  // stage 1: window update
  // --------------------------------------------------------------------------
  pos_t wstart_q, wstart_d;
  len_t best_q, best_d;
  logic ovf_q, ovf_d;

  logic             out_vld_q, out_vld_d;
  len_t             out_len_q;
  logic             out_ovf_q;

  logic             in_range;
  logic             hit;
  pos_t             prev_pos;
  pos_t             new_wstart;
  logic [PosW:0]    win_len;
  len_t             best_upd;
  logic             ovf_upd;

  // a result may only be loaded when the output register is free or drains
  assign s1_fire = s1_vld_q && (!s1_last_q || !out_vld_q || m_axis_tready);

  always_comb begin
    in_range   = pos_q < MaxLenPos;
    prev_pos   = (fwd_vld_q && (fwd_addr_q == s1_ch_q)) ? fwd_data_q : tbl_rdata;
    hit        = seen_q[s1_ch_q] && (prev_pos >= wstart_q);
    new_wstart = hit ? (prev_pos + pos_t'(1)) : wstart_q;
    win_len    = {1'b0, pos_q - new_wstart} + (PosW+1)'(1);
    best_upd   = best_q;
    ovf_upd    = ovf_q;
    if (in_range) begin
      if (win_len > {{(PosW+1-LenW){1'b0}}, best_q}) begin
        best_upd = LenW'(win_len);
      end
    end else begin
      ovf_upd = 1'b1;
    end
  end

  assign tbl_we = s1_fire && in_range;

  always_comb begin
    s1_vld_d  = s1_vld_q;
    seen_d    = seen_q;
    fwd_vld_d = fwd_vld_q;
    wstart_d  = wstart_q;
    pos_d     = pos_q;
    best_d    = best_q;
    ovf_d     = ovf_q;
    out_vld_d = out_vld_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    if (s1_fire) begin
      s1_vld_d  = 1'b0;
      fwd_vld_d = in_range;
      best_d    = best_upd;
      ovf_d     = ovf_upd;
      if (in_range) begin
        seen_d[s1_ch_q] = 1'b1;
        wstart_d        = new_wstart;
        pos_d           = pos_q + pos_t'(1);
      end
      if (s1_last_q) begin
        // result leaves, state returns to its reset value
        out_vld_d = 1'b1;
        seen_d    = '0;
        fwd_vld_d = 1'b0;
        wstart_d  = '0;
        pos_d     = '0;
        best_d    = '0;
        ovf_d     = 1'b0;
      end
    end

    if (in_xfer) begin
      s1_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      seen_q    <= '0;
      fwd_vld_q <= 1'b0;
      wstart_q  <= '0;
      pos_q     <= '0;
      best_q    <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      seen_q    <= seen_d;
      fwd_vld_q <= fwd_vld_d;
      wstart_q  <= wstart_d;
      pos_q     <= pos_d;
      best_q    <= best_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ch_q   <= in_sym;
      s1_last_q <= s_axis_tlast;
    end
    if (s1_fire && in_range) begin
      fwd_addr_q <= s1_ch_q;
      fwd_data_q <= pos_q;
    end
    if (s1_fire && s1_last_q) begin
      out_len_q <= best_upd;
      out_ovf_q <= ovf_upd;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(16-LenW){1'b0}}, out_len_q};
  assign m_axis_tuser  = out_ovf_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, s1_fire && s1_last_q,
    (seen_q == '0) && (pos_q == '0) && (best_q == '0) && !ovf_q,
    "state not cleared after the last byte")
  `ASSERT_IMPLIES(a_no_result_overrun, clk_i, rst_ni,
    out_vld_q && !m_axis_tready && s1_vld_q && s1_last_q, !s1_fire,
    "result overwrote a pending result")
  `ASSERT_ALWAYS(a_best_bounded, clk_i, rst_ni, best_q <= len_t'(AlphabetSize),
    "best length exceeds the alphabet size")
  `ASSERT_ALWAYS(a_window_order, clk_i, rst_ni, wstart_q <= pos_q,
    "window start passed the byte position")

endmodule

`default_nettype wire

// File: tb/longest_distinct_run_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker_core_tb
// self-checking bench for the longest distinct run tracker: strings are
// streamed in byte by byte, an in-bench model of the sliding window predicts
// the length reported on each last byte, and every result transfer is
// compared in order against those predictions
// ----------------------------------------------------------------------------

module longest_distinct_run_tracker_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ldrt_pkg::*;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 6;
  // the final result has come out before this tail, so a short tail is enough
  localparam int unsigned DrainCycles = 10;
  // longest quiet stretch of a correct run comes from random stalls plus
  // the tail above; this limit lies far beyond it
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned PhaseItems  = 470;
  localparam int unsigned PhaseReports = 8;

  typedef sym_t sym_queue_t[$];

  // one result: run length and overflow flag
  typedef struct packed {
    len_t longest;
    logic overflow;
  } run_report_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] ch
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [8:0] longest, [15:9] zero
  logic        m_axis_tuser;         // [0] overflow

  // idle chances in percent, changed per phase
  int unsigned send_gap_pct  = 0;
  int unsigned ready_gap_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned reports_seen   = 0;
  int unsigned quiet_cycles   = 0;

  run_report_t expected_reports[$];

  // window state of the string in flight
  logic [16:0] last_seen [AlphabetSize];  // position plus one, zero if unseen
  pos_t        window_head;
  pos_t        bytes_taken;
  int unsigned best_run;
  logic        too_long;

  longest_distinct_run_tracker_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // receiver stalls at random, decided at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= ready_gap_pct);
  end

  // ends the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    run_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual longest %0d overflow %0b",
                 $realtime, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        // padding above the length must be zero too
        if (m_axis_tdata !== 16'(want.longest)) begin
          $display("%0t: longest mismatch, expected %0d, actual %0d",
                   $realtime, want.longest, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.overflow) begin
          $display("%0t: overflow mismatch, expected %0b, actual %0b",
                   $realtime, want.overflow, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  function void clear_window();
    foreach (last_seen[i]) last_seen[i] = '0;
    window_head = '0;
    bytes_taken = '0;
    best_run    = 0;
    too_long    = 1'b0;
  endfunction

  // advances the sliding window by one accepted byte
  function void track_byte(input sym_t ch, input logic last_byte);
    int unsigned prev;
    int unsigned run_len;
    // byte values index the table directly, the alphabet is full width
    if (bytes_taken < MaxLenPos) begin
      prev = 32'(last_seen[ch]);
      // earlier copy inside the window: restart just past it
      if (prev != 0 && prev - 1 >= window_head) window_head = pos_t'(prev);
      last_seen[ch] = 17'(bytes_taken) + 17'd1;
      run_len = 32'(bytes_taken) - 32'(window_head) + 1;
      if (run_len > best_run) best_run = run_len;
      bytes_taken++;
    end else begin
      // past the length limit: byte only marks the overflow
      too_long = 1'b1;
    end
    if (last_byte) begin
      expected_reports.push_back('{longest: len_t'(best_run), overflow: too_long});
      clear_window();
    end
  endfunction

  // drives one byte from a falling edge and returns at the next falling
  // edge after its transfer; valid stays high for a following byte
  task automatic send_byte(input sym_t ch, input logic last_byte);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last_byte;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    track_byte(ch, last_byte);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input sym_queue_t str);
    foreach (str[i]) send_byte(str[i], i == str.size() - 1);
  endtask

  // holds the input off until every predicted result has come out
  task automatic wait_for_reports();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
  endtask

  function automatic sym_queue_t shuffled_alphabet();
    sym_queue_t q;
    int unsigned j;
    sym_t t;
    for (int i = 0; i < AlphabetSize; i++) q.push_back(sym_t'(i));
    for (int i = AlphabetSize - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    return q;
  endfunction

  // byte extremes, one-byte strings, repeats inside and outside the window
  task automatic test_directed();
    sym_queue_t str;
    str = {8'h00};
    send_string(str);
    str = {8'hFF};
    send_string(str);
    // second A repeats after the window already moved past it
    str = {8'h41, 8'h42, 8'h42, 8'h41};
    send_string(str);
    str = {8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62};
    send_string(str);
    str = {8'h70, 8'h77, 8'h77, 8'h6B, 8'h65, 8'h77};
    send_string(str);
    str = {8'hFF, 8'h00, 8'hFF};
    send_string(str);
  endtask

  // every byte value once, then the first again, so the longest run is the whole alphabet
  task automatic test_full_alphabet();
    sym_queue_t str;
    str = shuffled_alphabet();
    str.push_back(str[0]);
    send_string(str);
  endtask

  task automatic send_random_string();
    sym_queue_t str;
    int unsigned len;
    int unsigned base;
    int unsigned span;
    int unsigned mode;
    mode = $urandom_range(19);
    if (mode <= 11) begin
      // short strings over a narrow byte range: many repeats
      len  = $urandom_range(1, 24);
      base = $urandom_range(255);
      span = $urandom_range(2, 12);
      repeat (len) str.push_back(sym_t'(base + $urandom_range(span - 1)));
    end else if (mode <= 17) begin
      len = $urandom_range(1, 80);
      repeat (len) str.push_back(sym_t'($urandom_range(255)));
    end else if (mode == 18) begin
      len  = $urandom_range(200, 320);
      base = $urandom_range(255);
      span = $urandom_range(64, 256);
      repeat (len) str.push_back(sym_t'(base + $urandom_range(span - 1)));
    end else begin
      // permutation of all bytes with a random tail
      str = shuffled_alphabet();
      repeat ($urandom_range(40)) str.push_back(sym_t'($urandom_range(255)));
    end
    send_string(str);
  endtask

  task automatic test_random_strings(input int unsigned items);
    int unsigned first_byte;
    int unsigned first_report;
    first_byte   = bytes_sent;
    first_report = reports_seen;
    while (bytes_sent - first_byte < items || reports_seen - first_report < PhaseReports) begin
      send_random_string();
      // now and then let the results drain with the input held off
      if ($urandom_range(29) == 0) wait_for_reports();
    end
  endtask

  initial begin
    clear_window();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles more rarely than the receiver stalls
    send_gap_pct  = 31;
    ready_gap_pct = 45;
    test_directed();
    test_full_alphabet();
    test_random_strings(PhaseItems);
    wait_for_reports();

    // roles swapped
    send_gap_pct  = 45;
    ready_gap_pct = 31;
    test_random_strings(PhaseItems);
    wait_for_reports();

    // full rate on both sides
    send_gap_pct  = 0;
    ready_gap_pct = 0;
    test_random_strings(PhaseItems);

    wait_for_reports();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
